### src/hbp_pkg.sv
// Package for the HTTP header byte parser: types, character codes and helper functions.
`default_nettype none

package hbp_pkg;

    // Default width of the header name byte counter.
    localparam int HBP_NAME_LEN_BITS = 8;

    // Character codes that steer the parse.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Parse phases of one header line.
    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_NAME    = 3'd1,
        PH_SPACE   = 3'd2,
        PH_VALUE   = 3'd3,
        PH_LINE_CR = 3'd4,
        PH_END_CR  = 3'd5,
        PH_ERROR   = 3'd6
    } t_phase;

    // Kind of the byte handed on with a result.
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_NAME  = 2'd1,
        KIND_VALUE = 2'd2
    } t_kind;

    // Event reported with a result.
    typedef enum logic [1:0] {
        EV_CONT = 2'd0,
        EV_LINE = 2'd1,
        EV_END  = 2'd2,
        EV_ERR  = 2'd3
    } t_event;

    // Error codes, held while the parser sits in the error phase.
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_NAME  = 2'd1,
        ERR_VALUE = 2'd2,
        ERR_EOL   = 2'd3
    } t_err;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] byte_kind;
        logic [1:0] event_res;
        logic [1:0] error_kind;
        logic [7:0] name_length;
    } t_result;

    // True for a letter, a digit or a hyphen.
    function automatic logic name_ok(input logic [7:0] b);
        name_ok = (b inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39], 8'h2D});
    endfunction

    // Lower-cases an upper-case letter and passes every other byte unchanged.
    function automatic logic [7:0] name_lower(input logic [7:0] b);
        name_lower = (b inside {[8'h41:8'h5A]}) ? (b + 8'h20) : b;
    endfunction

endpackage

`default_nettype wire

### src/hbp_ifs.sv
// Valid/ready channel interfaces for the parser's byte input and result output.
`default_nettype none

// Input channel: one raw header byte per request.
interface hbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// Output channel: one parse result per request.
interface hbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic [1:0] event_res;
    logic [1:0] error_kind;
    logic [7:0] name_length;

    modport source (output valid, output out_byte, output byte_kind, output event_res,
                    output error_kind, output name_length, input ready);
    modport sink   (input valid, input out_byte, input byte_kind, input event_res,
                    input error_kind, input name_length, output ready);
endinterface

`default_nettype wire

### src/hbp_step.sv
// Per-byte parse step: next parser state and the result for one header byte.
`default_nettype none

module hbp_step #(
    parameter int NAME_LEN_BITS = hbp_pkg::HBP_NAME_LEN_BITS
) (
    input  wire logic [7:0]               i_byte,
    input  wire hbp_pkg::t_phase          i_phase,
    input  wire hbp_pkg::t_err            i_err,
    input  wire logic [NAME_LEN_BITS-1:0] i_count,
    input  wire logic [NAME_LEN_BITS-1:0] i_len,
    output hbp_pkg::t_phase               o_phase,
    output hbp_pkg::t_err                 o_err,
    output logic [NAME_LEN_BITS-1:0]      o_count,
    output logic [NAME_LEN_BITS-1:0]      o_len,
    output hbp_pkg::t_result              o_res
);

    localparam logic [NAME_LEN_BITS-1:0] CountMax = '1;

    logic                     is_name;
    logic [7:0]               lower_byte;
    logic [NAME_LEN_BITS-1:0] count_inc;
    logic [15:0]              len_wide;
    logic [7:0]               len_sat;

    // Character class and the saturating name counter.
    assign is_name    = hbp_pkg::name_ok(i_byte);
    assign lower_byte = hbp_pkg::name_lower(i_byte);
    assign count_inc  = (i_count == CountMax) ? i_count : (i_count + 1'b1);

    // Latched name length, clamped to the eight bits of the result field.
    assign len_wide = 16'(i_len);
    assign len_sat  = (len_wide > 16'd255) ? 8'hFF : len_wide[7:0];

    // Next state of the parser.
    always_comb begin
        o_phase = i_phase;
        o_err   = i_err;
        o_count = i_count;
        o_len   = i_len;
        case (i_phase)
            hbp_pkg::PH_START: begin
                o_count = '0;
                o_len   = '0;
                if (i_byte == hbp_pkg::CH_CR) begin
                    o_phase = hbp_pkg::PH_END_CR;
                end else if (i_byte == hbp_pkg::CH_LF) begin
                    o_phase = hbp_pkg::PH_START;
                end else if (is_name) begin
                    o_phase = hbp_pkg::PH_NAME;
                    o_count = NAME_LEN_BITS'(1);
                end else begin
                    o_phase = hbp_pkg::PH_ERROR;
                    o_err   = hbp_pkg::ERR_NAME;
                end
            end
            hbp_pkg::PH_NAME: begin
                if (is_name) begin
                    o_count = count_inc;
                end else if (i_byte == hbp_pkg::CH_COLON) begin
                    o_len   = i_count;
                    o_phase = hbp_pkg::PH_SPACE;
                end else if (i_byte == hbp_pkg::CH_CR) begin
                    o_phase = hbp_pkg::PH_LINE_CR;
                end else if (i_byte == hbp_pkg::CH_LF) begin
                    o_phase = hbp_pkg::PH_START;
                end else begin
                    o_phase = hbp_pkg::PH_ERROR;
                    o_err   = hbp_pkg::ERR_NAME;
                end
            end
            hbp_pkg::PH_SPACE: begin
                if (i_byte == hbp_pkg::CH_SPACE) begin
                    o_phase = hbp_pkg::PH_SPACE;
                end else if (i_byte == hbp_pkg::CH_CR) begin
                    o_phase = hbp_pkg::PH_LINE_CR;
                end else if (i_byte == hbp_pkg::CH_LF) begin
                    o_phase = hbp_pkg::PH_START;
                end else if (i_byte == hbp_pkg::CH_NUL) begin
                    o_phase = hbp_pkg::PH_ERROR;
                    o_err   = hbp_pkg::ERR_NAME;
                end else begin
                    o_phase = hbp_pkg::PH_VALUE;
                end
            end
            hbp_pkg::PH_VALUE: begin
                if (i_byte == hbp_pkg::CH_CR) begin
                    o_phase = hbp_pkg::PH_LINE_CR;
                end else if (i_byte == hbp_pkg::CH_LF) begin
                    o_phase = hbp_pkg::PH_START;
                end else if (i_byte == hbp_pkg::CH_NUL) begin
                    o_phase = hbp_pkg::PH_ERROR;
                    o_err   = hbp_pkg::ERR_VALUE;
                end
            end
            hbp_pkg::PH_LINE_CR: begin
                if (i_byte == hbp_pkg::CH_LF) begin
                    o_phase = hbp_pkg::PH_START;
                end else if (i_byte != hbp_pkg::CH_CR) begin
                    o_phase = hbp_pkg::PH_ERROR;
                    o_err   = hbp_pkg::ERR_EOL;
                end
            end
            hbp_pkg::PH_END_CR: begin
                if (i_byte == hbp_pkg::CH_LF) begin
                    o_phase = hbp_pkg::PH_START;
                end else begin
                    o_phase = hbp_pkg::PH_ERROR;
                    o_err   = hbp_pkg::ERR_EOL;
                end
            end
            default: begin
                // The error phase, and any unused code, holds until reset.
                o_phase = i_phase;
            end
        endcase
    end

    // Result fields for the byte.
    always_comb begin
        o_res = '0;
        case (i_phase)
            hbp_pkg::PH_START: begin
                if (i_byte == hbp_pkg::CH_LF) begin
                    o_res.event_res = hbp_pkg::EV_END;
                end else if (is_name) begin
                    o_res.out_byte  = lower_byte;
                    o_res.byte_kind = hbp_pkg::KIND_NAME;
                end
            end
            hbp_pkg::PH_NAME: begin
                if (is_name) begin
                    o_res.out_byte  = lower_byte;
                    o_res.byte_kind = hbp_pkg::KIND_NAME;
                end else if (i_byte == hbp_pkg::CH_LF) begin
                    o_res.event_res   = hbp_pkg::EV_LINE;
                    o_res.name_length = len_sat;
                end
            end
            hbp_pkg::PH_SPACE: begin
                if (i_byte == hbp_pkg::CH_LF) begin
                    o_res.event_res   = hbp_pkg::EV_LINE;
                    o_res.name_length = len_sat;
                end else if (i_byte != hbp_pkg::CH_SPACE && i_byte != hbp_pkg::CH_CR) begin
                    o_res.out_byte  = i_byte;
                    o_res.byte_kind = hbp_pkg::KIND_VALUE;
                end
            end
            hbp_pkg::PH_VALUE: begin
                if (i_byte == hbp_pkg::CH_LF) begin
                    o_res.event_res   = hbp_pkg::EV_LINE;
                    o_res.name_length = len_sat;
                end else if (i_byte != hbp_pkg::CH_CR) begin
                    o_res.out_byte  = i_byte;
                    o_res.byte_kind = hbp_pkg::KIND_VALUE;
                end
            end
            hbp_pkg::PH_LINE_CR: begin
                if (i_byte == hbp_pkg::CH_LF) begin
                    o_res.event_res   = hbp_pkg::EV_LINE;
                    o_res.name_length = len_sat;
                end
            end
            hbp_pkg::PH_END_CR: begin
                if (i_byte == hbp_pkg::CH_LF) begin
                    o_res.event_res = hbp_pkg::EV_END;
                end
            end
            default: begin
                o_res.event_res  = hbp_pkg::EV_ERR;
                o_res.error_kind = i_err;
            end
        endcase
        // Any byte that lands in the error phase reports only the error.
        if (o_phase == hbp_pkg::PH_ERROR) begin
            o_res            = '0;
            o_res.event_res  = hbp_pkg::EV_ERR;
            o_res.error_kind = o_err;
        end
    end

endmodule

`default_nettype wire

### src/http_header_byte_parser.sv
// Top level of the HTTP header byte parser: state registers and result register.
`default_nettype none

// Parses an HTTP header section one byte per request and returns exactly one result
// per byte: the lower-cased name byte or the value byte to append, and an event
// (continue, header line done with the name length, end of headers, or error with
// its code). A byte is accepted in every cycle while the result register is empty or
// being drained; its result is registered and appears in the cycle after acceptance.
// The rate is set by the combinational parse step between the state registers and the
// result register: one byte per cycle while the output is not stalled. CR LF and a
// bare LF both end a line; an empty line ends the header section and the parser is
// ready for the next one. An error is sticky until reset. The name counter is
// NAME_LEN_BITS wide and saturates; the reported name length saturates at 255.
module http_header_byte_parser #(
    parameter int NAME_LEN_BITS = hbp_pkg::HBP_NAME_LEN_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hbp_in_if.sink     i_in,
    hbp_out_if.source  o_out
);

    hbp_pkg::t_phase          r_phase, n_phase;
    hbp_pkg::t_err            r_err, n_err;
    logic [NAME_LEN_BITS-1:0] r_count, n_count;
    logic [NAME_LEN_BITS-1:0] r_len, n_len;
    hbp_pkg::t_result         r_res, n_res;
    logic                     r_out_valid;
    logic                     in_accept;

    // A new request is taken while the result register is free or being drained.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_accept  = i_in.valid && i_in.ready;

    // Parse step for the incoming byte.
    hbp_step #(
        .NAME_LEN_BITS (NAME_LEN_BITS)
    ) u_step (
        .i_byte  (i_in.in_byte),
        .i_phase (r_phase),
        .i_err   (r_err),
        .i_count (r_count),
        .i_len   (r_len),
        .o_phase (n_phase),
        .o_err   (n_err),
        .o_count (n_count),
        .o_len   (n_len),
        .o_res   (n_res)
    );

    // Parser state, updated on every accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= hbp_pkg::PH_START;
            r_err   <= hbp_pkg::ERR_NONE;
            r_count <= '0;
            r_len   <= '0;
        end else if (in_accept) begin
            r_phase <= n_phase;
            r_err   <= n_err;
            r_count <= n_count;
            r_len   <= n_len;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= n_res;
        end
    end

    // Output channel.
    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_res.out_byte;
    assign o_out.byte_kind   = r_res.byte_kind;
    assign o_out.event_res   = r_res.event_res;
    assign o_out.error_kind  = r_res.error_kind;
    assign o_out.name_length = r_res.name_length;

    // Once in the error phase, every later byte reports an error.
    a_sticky_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == hbp_pkg::PH_ERROR)
            |=> (r_out_valid && r_res.event_res == hbp_pkg::EV_ERR))
        else $error("error phase did not report an error");

    // An error code is present exactly when the event is an error.
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_res.event_res == hbp_pkg::EV_ERR)
                         == (r_res.error_kind != hbp_pkg::ERR_NONE)))
        else $error("error code and event disagree");

    // A byte handed on comes with a plain continue event and no name length.
    a_byte_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.byte_kind != hbp_pkg::KIND_NONE)
            |-> (r_res.event_res == hbp_pkg::EV_CONT && r_res.name_length == 8'd0))
        else $error("byte result carries an event");

    // Every accepted byte leaves a result in the register.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted byte produced no result");

endmodule

`default_nettype wire

### verif/http_header_byte_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the HTTP header byte parser: random and directed byte streams.
module http_header_byte_parser_tb;

    localparam int NAME_BITS    = hbp_pkg::HBP_NAME_LEN_BITS;
    localparam int RANDOM_ITEMS = 700;
    localparam int IDLE_PERCENT = 17;
    localparam int LONG_HOLD    = 90;
    localparam int NOISE_BYTES  = 30;
    localparam int LIMIT_CYCLES = 200000;

    // Ways of breaking a header line at the end of the run.
    typedef enum int {
        BREAK_FIRST_BYTE,
        BREAK_NAME_BYTE,
        BREAK_GAP_NUL,
        BREAK_VALUE_NUL,
        BREAK_LINE_CR,
        BREAK_END_CR
    } t_break;

    // Tracks the parser state and holds the results expected for accepted requests.
    class header_parse_scoreboard;
        hbp_pkg::t_result     expected_q[$];
        hbp_pkg::t_phase      phase         = hbp_pkg::PH_START;
        logic [NAME_BITS-1:0] name_count    = '0;
        logic [NAME_BITS-1:0] name_len_held = '0;
        hbp_pkg::t_err        err_held      = hbp_pkg::ERR_NONE;
        hbp_pkg::t_err        err_seen      = hbp_pkg::ERR_NONE;
        int requests, results, mismatches;
        int lines_done, sections_done, name_bytes, value_bytes;

        // Lower-cased name character, or zero when the byte cannot be part of a name.
        static function logic [7:0] fold_name_char(logic [7:0] b);
            if (b >= 8'h41 && b <= 8'h5A) return b + 8'h20;
            if ((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h30 && b <= 8'h39) || b == 8'h2D)
                return b;
            return 8'h00;
        endfunction

        function void count_name_byte();
            if (name_count != {NAME_BITS{1'b1}}) name_count++;
        endfunction

        // Advances the parser state by one byte and queues the result it causes.
        function void note_request(logic [7:0] b);
            hbp_pkg::t_result exp;
            hbp_pkg::t_event  ev;
            logic [7:0]       c;
            exp = '0;
            ev  = hbp_pkg::EV_CONT;
            c   = fold_name_char(b);
            requests++;
            case (phase)
                hbp_pkg::PH_START: begin
                    name_count    = '0;
                    name_len_held = '0;
                    if (b == hbp_pkg::CH_CR) begin
                        phase = hbp_pkg::PH_END_CR;
                    end else if (b == hbp_pkg::CH_LF) begin
                        ev = hbp_pkg::EV_END;
                    end else if (c != 8'h00) begin
                        phase         = hbp_pkg::PH_NAME;
                        exp.out_byte  = c;
                        exp.byte_kind = hbp_pkg::KIND_NAME;
                        count_name_byte();
                    end else begin
                        err_held = hbp_pkg::ERR_NAME;
                        phase    = hbp_pkg::PH_ERROR;
                    end
                end
                hbp_pkg::PH_NAME: begin
                    if (c != 8'h00) begin
                        exp.out_byte  = c;
                        exp.byte_kind = hbp_pkg::KIND_NAME;
                        count_name_byte();
                    end else if (b == hbp_pkg::CH_COLON) begin
                        name_len_held = name_count;
                        phase         = hbp_pkg::PH_SPACE;
                    end else if (b == hbp_pkg::CH_CR) begin
                        phase = hbp_pkg::PH_LINE_CR;
                    end else if (b == hbp_pkg::CH_LF) begin
                        ev = hbp_pkg::EV_LINE;
                    end else begin
                        err_held = hbp_pkg::ERR_NAME;
                        phase    = hbp_pkg::PH_ERROR;
                    end
                end
                hbp_pkg::PH_SPACE: begin
                    if (b == hbp_pkg::CH_SPACE) begin
                        // Leading spaces of the value are dropped.
                    end else if (b == hbp_pkg::CH_CR) begin
                        phase = hbp_pkg::PH_LINE_CR;
                    end else if (b == hbp_pkg::CH_LF) begin
                        ev = hbp_pkg::EV_LINE;
                    end else if (b == hbp_pkg::CH_NUL) begin
                        err_held = hbp_pkg::ERR_NAME;
                        phase    = hbp_pkg::PH_ERROR;
                    end else begin
                        exp.out_byte  = b;
                        exp.byte_kind = hbp_pkg::KIND_VALUE;
                        phase         = hbp_pkg::PH_VALUE;
                    end
                end
                hbp_pkg::PH_VALUE: begin
                    if (b == hbp_pkg::CH_CR) begin
                        phase = hbp_pkg::PH_LINE_CR;
                    end else if (b == hbp_pkg::CH_LF) begin
                        ev = hbp_pkg::EV_LINE;
                    end else if (b == hbp_pkg::CH_NUL) begin
                        err_held = hbp_pkg::ERR_VALUE;
                        phase    = hbp_pkg::PH_ERROR;
                    end else begin
                        exp.out_byte  = b;
                        exp.byte_kind = hbp_pkg::KIND_VALUE;
                    end
                end
                hbp_pkg::PH_LINE_CR: begin
                    // A further CR inside a line is ignored.
                    if (b == hbp_pkg::CH_LF) begin
                        ev = hbp_pkg::EV_LINE;
                    end else if (b != hbp_pkg::CH_CR) begin
                        err_held = hbp_pkg::ERR_EOL;
                        phase    = hbp_pkg::PH_ERROR;
                    end
                end
                hbp_pkg::PH_END_CR: begin
                    if (b == hbp_pkg::CH_LF) begin
                        ev = hbp_pkg::EV_END;
                    end else begin
                        err_held = hbp_pkg::ERR_EOL;
                        phase    = hbp_pkg::PH_ERROR;
                    end
                end
                default: begin
                end
            endcase

            // Line and section ends go back to line start; an error wins over everything.
            if (ev == hbp_pkg::EV_LINE) begin
                exp.name_length = (name_len_held > 255) ? 8'd255 : 8'(name_len_held);
                phase           = hbp_pkg::PH_START;
            end else if (ev == hbp_pkg::EV_END) begin
                phase = hbp_pkg::PH_START;
            end
            if (phase == hbp_pkg::PH_ERROR) begin
                exp            = '0;
                ev             = hbp_pkg::EV_ERR;
                exp.error_kind = err_held;
            end
            exp.event_res = ev;
            expected_q.push_back(exp);
        endfunction

        function void report(string what, hbp_pkg::t_result exp, hbp_pkg::t_result got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s: expected byte=%02h kind=%0d event=%0d error=%0d length=%0d",
                         what, exp.out_byte, exp.byte_kind, exp.event_res, exp.error_kind,
                         exp.name_length);
                $display("    actual byte=%02h kind=%0d event=%0d error=%0d length=%0d",
                         got.out_byte, got.byte_kind, got.event_res, got.error_kind,
                         got.name_length);
            end
        endfunction

        // Compares one result with the oldest expectation, field by field.
        function void check_result(hbp_pkg::t_result got);
            hbp_pkg::t_result exp;
            results++;
            if (expected_q.size() == 0) begin
                report("Result without a pending request", '0, got);
                return;
            end
            exp = expected_q.pop_front();
            if (got.out_byte !== exp.out_byte || got.byte_kind !== exp.byte_kind ||
                got.event_res !== exp.event_res || got.error_kind !== exp.error_kind ||
                got.name_length !== exp.name_length) begin
                report("Result mismatch", exp, got);
            end
            case (exp.event_res)
                hbp_pkg::EV_LINE: lines_done++;
                hbp_pkg::EV_END:  sections_done++;
                hbp_pkg::EV_ERR:  err_seen = hbp_pkg::t_err'(exp.error_kind);
                default: begin
                end
            endcase
            if (exp.byte_kind == hbp_pkg::KIND_NAME) name_bytes++;
            if (exp.byte_kind == hbp_pkg::KIND_VALUE) value_bytes++;
        endfunction

        // Any expectation still waiting at the end is a failure.
        function void close_out();
            if (expected_q.size() != 0) begin
                $display("%0d expected results never arrived", expected_q.size());
                mismatches += expected_q.size();
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycle_count = 0;
    int   sent_items  = 0;
    bit   steady_run  = 1'b0;
    bit   hold_wanted = 1'b0;

    header_parse_scoreboard sb = new;

    hbp_in_if  in_if ();
    hbp_out_if out_if ();

    http_header_byte_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Watchdog: a hung handshake ends the run here.
    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) @(posedge i_clk);
        $display("Timeout after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
    end

    // Both channels are sampled at the clock edge, before any new drive takes effect.
    always @(posedge i_clk) begin : channel_monitor
        hbp_pkg::t_result seen;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen.out_byte    = out_if.out_byte;
            seen.byte_kind   = out_if.byte_kind;
            seen.event_res   = out_if.event_res;
            seen.error_kind  = out_if.error_kind;
            seen.name_length = out_if.name_length;
            sb.check_result(seen);
        end
        if (i_rst_n && in_if.valid && in_if.ready) sb.note_request(in_if.in_byte);
    end

    // Result side: random back-pressure, one long hold-off when asked for.
    initial begin : result_sink
        int  held;
        bit  hold_over;
        hold_over = 1'b0;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_wanted && !hold_over) begin
                out_if.ready <= 1'b0;
                for (held = 0; held < LONG_HOLD; held++) @(posedge i_clk);
                hold_over = 1'b1;
            end else begin
                out_if.ready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
                @(posedge i_clk);
            end
        end
    end

    // Offers one byte after a random gap and waits until the request is taken.
    task automatic drive_request(input logic [7:0] b);
        while (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic drive_text(input string s);
        for (int i = 0; i < s.len(); i++) drive_request(s[i]);
    endtask

    // Drops valid and waits until every expected result has come back.
    task automatic pause_until_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] random_name_char();
        int r;
        r = $urandom_range(62);
        if (r < 26) return 8'h41 + 8'(r);
        if (r < 52) return 8'h61 + 8'(r - 26);
        if (r < 62) return 8'h30 + 8'(r - 52);
        return 8'h2D;
    endfunction

    // Any byte that keeps a value going.
    function automatic logic [7:0] random_value_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b == hbp_pkg::CH_CR || b == hbp_pkg::CH_LF);
        return b;
    endfunction

    // A byte that is neither a name character nor a line ending.
    function automatic logic [7:0] stray_name_byte(input bit allow_colon);
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while (header_parse_scoreboard::fold_name_char(b) != 8'h00 || b == hbp_pkg::CH_CR ||
               b == hbp_pkg::CH_LF || (!allow_colon && b == hbp_pkg::CH_COLON));
        return b;
    endfunction

    // CR LF, a bare LF, or (inside a line only) a doubled CR.
    task automatic drive_line_end(input bit allow_double_cr);
        int r;
        r = $urandom_range(99);
        if (r < 60 || (!allow_double_cr && r < 70)) begin
            drive_request(hbp_pkg::CH_CR);
        end else if (r < 70) begin
            drive_request(hbp_pkg::CH_CR);
            drive_request(hbp_pkg::CH_CR);
        end
        drive_request(hbp_pkg::CH_LF);
    endtask

    // One well-formed header line; a few have no colon at all.
    task automatic drive_header_line(input int name_len);
        int spaces;
        int value_len;
        for (int i = 0; i < name_len; i++) drive_request(random_name_char());
        if ($urandom_range(99) < 85) begin
            drive_request(hbp_pkg::CH_COLON);
            spaces    = $urandom_range(3);
            value_len = $urandom_range(12);
            repeat (spaces) drive_request(hbp_pkg::CH_SPACE);
            repeat (value_len) drive_request(random_value_byte());
        end
        drive_line_end(1'b1);
    endtask

    // A header section: some lines, then the empty line.
    task automatic drive_header_section(input bit long_name);
        int lines;
        lines = $urandom_range(1, 5);
        for (int i = 0; i < lines; i++) begin
            if (long_name && i == 0) drive_header_line($urandom_range(256, 300));
            else drive_header_line($urandom_range(1, 10));
        end
        drive_line_end(1'b0);
    endtask

    // A malformed line; the parser stays in its error state from here on.
    task automatic drive_broken_line();
        t_break     shape;
        logic [7:0] b;
        shape = t_break'($urandom_range(5));
        case (shape)
            BREAK_FIRST_BYTE: begin
                drive_request(stray_name_byte(1'b1));
            end
            BREAK_NAME_BYTE: begin
                drive_request(random_name_char());
                drive_request(stray_name_byte(1'b0));
            end
            BREAK_GAP_NUL: begin
                drive_request(random_name_char());
                drive_request(hbp_pkg::CH_COLON);
                repeat ($urandom_range(2)) drive_request(hbp_pkg::CH_SPACE);
                drive_request(hbp_pkg::CH_NUL);
            end
            BREAK_VALUE_NUL: begin
                drive_request(random_name_char());
                drive_request(hbp_pkg::CH_COLON);
                drive_request(random_value_byte());
                drive_request(hbp_pkg::CH_NUL);
            end
            BREAK_LINE_CR: begin
                drive_request(random_name_char());
                drive_request(hbp_pkg::CH_CR);
                do b = 8'($urandom_range(255));
                while (b == hbp_pkg::CH_CR || b == hbp_pkg::CH_LF);
                drive_request(b);
            end
            default: begin
                drive_request(hbp_pkg::CH_CR);
                do b = 8'($urandom_range(255)); while (b == hbp_pkg::CH_LF);
                drive_request(b);
            end
        endcase
    endtask

    initial begin : stimulus
        int section_no;
        section_no = 0;
        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.in_byte <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: case folding, hyphen and digits, value byte extremes, doubled CR.
        drive_text("X-9: ");
        drive_request(8'h01);
        drive_request(8'hFF);
        drive_request(hbp_pkg::CH_COLON);
        drive_request(hbp_pkg::CH_CR);
        drive_request(hbp_pkg::CH_CR);
        drive_request(hbp_pkg::CH_LF);
        // Line without a colon, ended by a bare LF.
        drive_text("zA");
        drive_request(hbp_pkg::CH_LF);
        // Empty value, then an empty CR LF line ends the section.
        drive_text("a:");
        drive_request(hbp_pkg::CH_CR);
        drive_request(hbp_pkg::CH_LF);
        drive_request(hbp_pkg::CH_CR);
        drive_request(hbp_pkg::CH_LF);
        // Colon straight into a bare LF, then a bare LF ends the section.
        drive_text("0:");
        drive_request(hbp_pkg::CH_LF);
        drive_request(hbp_pkg::CH_LF);
        pause_until_drained();

        // Random well-formed sections, one with a name long enough to saturate the count.
        while (sent_items < RANDOM_ITEMS) begin
            steady_run = (sent_items >= 350 && sent_items < 470);
            if (sent_items >= 150) hold_wanted = 1'b1;
            drive_header_section(section_no == 4);
            section_no++;
        end
        steady_run = 1'b0;
        pause_until_drained();

        // A broken line, then noise into the sticky error state.
        drive_broken_line();
        repeat (NOISE_BYTES) drive_request(8'($urandom_range(255)));
        pause_until_drained();
        repeat (8) @(posedge i_clk);
        sb.close_out();

        $display("Run covered %0d requests and %0d results: %0d header lines, %0d sections,",
                 sb.requests, sb.results, sb.lines_done, sb.sections_done);
        $display("%0d name bytes, %0d value bytes, closing error kind %0d.",
                 sb.name_bytes, sb.value_bytes, sb.err_seen);
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
